// File: design/dtsi_pkg.sv
package dtsi_pkg;

	localparam int VALUE_BITS_DEF = 64;
	localparam int COUNT_BITS_DEF = 16;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_INVAL = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	localparam int IN_TDATA_BITS  = 8;
	localparam int OUT_TDATA_BITS = 88;

	typedef struct packed {
		logic [7:0] ch;
		logic       window_end;
	} item_t;

	typedef struct packed {
		logic [15:0]        consumed;
		logic [1:0]         status;
		logic signed [63:0] value;
	} res_t;

	typedef struct packed {
		logic fire;
		logic take;
	} step_ctl_t;

endpackage

// File: design/dtsi_in_stage.sv
module dtsi_in_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  dtsi_pkg::item_t  s_item,
	input  logic             take,
	output logic             valid_s1,
	output dtsi_pkg::item_t  item_s1
);

	assign s_tready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= s_item;
		end
	end

endmodule

// File: design/dtsi_parse.sv
module dtsi_parse #(
	parameter int VALUE_BITS = dtsi_pkg::VALUE_BITS_DEF,
	parameter int COUNT_BITS = dtsi_pkg::COUNT_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid_s1,
	input  dtsi_pkg::item_t     item_s1,
	input  logic                out_free,
	output dtsi_pkg::step_ctl_t ctl,
	output dtsi_pkg::res_t      res
);

	localparam logic [1:0] PH_SKIP  = 2'd0;
	localparam logic [1:0] PH_SIGN  = 2'd1;
	localparam logic [1:0] PH_DIGIT = 2'd2;
	localparam logic [1:0] PH_DRAIN = 2'd3;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam int WIDE = VALUE_BITS + 4;

	localparam logic [WIDE-1:0] LIM_POS = {5'b0, {(VALUE_BITS-1){1'b1}}};
	localparam logic [WIDE-1:0] LIM_NEG = {4'b0, 1'b1, {(VALUE_BITS-1){1'b0}}};

	logic [1:0]            phase_q, phase_n;
	logic                  neg_q, neg_n;
	logic [VALUE_BITS-1:0] acc_q, acc_n;
	logic [COUNT_BITS-1:0] cnt_q, cnt_n, cnt_inc;

	logic                  is_ws, is_sign, is_digit, last;
	logic [WIDE-1:0]       acc_x, mul, lim;
	logic                  ovf;
	logic                  fire;
	logic [1:0]            status;
	logic signed [VALUE_BITS-1:0] sval;
	logic                  go;

	assign last     = item_s1.window_end;
	assign is_ws    = (item_s1.ch == CH_SPACE) || (item_s1.ch == CH_TAB);
	assign is_sign  = (item_s1.ch == CH_PLUS) || (item_s1.ch == CH_MINUS);
	assign is_digit = (item_s1.ch >= CH_ZERO) && (item_s1.ch <= CH_NINE);

	// acc*10 + d compared against the limit; same as acc > (lim - d) / 10
	assign acc_x   = WIDE'(acc_q);
	assign mul     = (acc_x << 3) + (acc_x << 1) + WIDE'(item_s1.ch[3:0]);
	assign lim     = neg_q ? LIM_NEG : LIM_POS;
	assign ovf     = mul > lim;
	assign cnt_inc = (&cnt_q) ? cnt_q : cnt_q + COUNT_BITS'(1);

	always_comb begin
		phase_n = phase_q;
		neg_n   = neg_q;
		acc_n   = acc_q;
		cnt_n   = cnt_q;
		fire    = 1'b0;
		status  = dtsi_pkg::ST_OK;
		case (phase_q)
			PH_SKIP, PH_SIGN, PH_DIGIT: begin
				if (phase_q == PH_SKIP && is_ws) begin
					cnt_n = cnt_inc;
					if (last) begin
						fire   = 1'b1;
						status = dtsi_pkg::ST_INVAL;
					end
				end else if (phase_q == PH_SKIP && is_sign) begin
					neg_n = (item_s1.ch == CH_MINUS);
					cnt_n = cnt_inc;
					if (last) begin
						fire   = 1'b1;
						status = dtsi_pkg::ST_INVAL;
					end else begin
						phase_n = PH_SIGN;
					end
				end else if (!is_digit) begin
					fire   = 1'b1;
					status = (phase_q == PH_DIGIT) ? dtsi_pkg::ST_OK : dtsi_pkg::ST_INVAL;
				end else if (ovf) begin
					acc_n  = '0;
					fire   = 1'b1;
					status = dtsi_pkg::ST_RANGE;
				end else begin
					acc_n   = mul[VALUE_BITS-1:0];
					cnt_n   = cnt_inc;
					phase_n = PH_DIGIT;
					if (last) begin
						fire   = 1'b1;
						status = dtsi_pkg::ST_OK;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign sval = neg_n ? $signed(-acc_n) : $signed(acc_n);

	assign res.value    = (status == dtsi_pkg::ST_OK) ? 64'(sval) : 64'sd0;
	assign res.status   = status;
	assign res.consumed = 16'(cnt_n);

	assign ctl.fire = fire;
	assign ctl.take = valid_s1 && (!fire || out_free);
	assign go       = ctl.take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SKIP;
			neg_q   <= 1'b0;
			acc_q   <= '0;
			cnt_q   <= '0;
		end else if (go) begin
			if (last && (fire || phase_q == PH_DRAIN)) begin
				phase_q <= PH_SKIP;
				neg_q   <= 1'b0;
				acc_q   <= '0;
				cnt_q   <= '0;
			end else begin
				phase_q <= fire ? PH_DRAIN : phase_n;
				neg_q   <= neg_n;
				acc_q   <= acc_n;
				cnt_q   <= cnt_n;
			end
		end
	end

endmodule

// File: design/dtsi_out_stage.sv
module dtsi_out_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  dtsi_pkg::res_t  res,
	output logic            out_free,
	output logic            m_tvalid,
	input  logic            m_tready,
	output dtsi_pkg::res_t  res_q
);

	assign out_free = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_free) begin
			m_tvalid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

// File: design/decimal_text_to_signed_int.sv
// Decimal text to signed integer parser.
// Slave stream: one ASCII character per beat in s_tdata[7:0]; s_tlast marks
// the last character of a text window. Leading spaces and tabs are skipped,
// one optional sign is taken, then decimal digits are accumulated.
// Master stream: one result beat per window, on the character where parsing
// stops; characters after it up to s_tlast are swallowed without output.
// m_tdata carries value (signed, 0 unless ok), status (0 ok, 1 invalid,
// 2 overflow) and the consumed count (saturating).
// Path: a character accepted on the slave stream is held in the input register,
// then passes once through the parse step into the output register that
// drives m_tvalid. Throughput: one character per cycle, save that a character
// that would produce a result waits while the output register is full; the
// step loop on the accumulator and phase registers is one combinational pass.
// Reset clears the parse state, the input register valid and m_tvalid; the
// block starts a fresh window and takes beats right after reset.
// Receiver stall: the result waits in the output register; characters that
// produce no result keep flowing, and a character that would produce a
// second result holds in the input register until the output drains.
module decimal_text_to_signed_int #(
	parameter int VALUE_BITS = dtsi_pkg::VALUE_BITS_DEF,
	parameter int COUNT_BITS = dtsi_pkg::COUNT_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [dtsi_pkg::IN_TDATA_BITS-1:0]   s_tdata,  // ch[7:0]
	input  logic                                 s_tlast,  // window_end
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [dtsi_pkg::OUT_TDATA_BITS-1:0] m_tdata // value[63:0], status[65:64], consumed[81:66]
);

	dtsi_pkg::item_t     s_item, item_s1;
	dtsi_pkg::step_ctl_t ctl;
	dtsi_pkg::res_t      res, res_q;
	logic                valid_s1, out_free, load;

	assign s_item.ch         = s_tdata[7:0];
	assign s_item.window_end = s_tlast;

	dtsi_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_item   (s_item),
		.take     (ctl.take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	dtsi_parse #(
		.VALUE_BITS (VALUE_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.out_free (out_free),
		.ctl      (ctl),
		.res      (res)
	);

	assign load = ctl.take && ctl.fire;

	dtsi_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.res      (res),
		.out_free (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.res_q    (res_q)
	);

	assign m_tdata = {6'b0, res_q.consumed, res_q.status, res_q.value};

	a_load_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> out_free)
		else $error("result loaded while output register full");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !load |=> !m_tvalid)
		else $error("result beat repeated");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (res_q.status != dtsi_pkg::ST_OK) |-> (res_q.value == 64'sd0))
		else $error("nonzero value on error status");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !ctl.take |=> valid_s1 && $stable(item_s1))
		else $error("stalled character lost");

endmodule
